/* hw/rtl/assert_macros.svh */
// assertion macros shared by the hash table rtl
// expects a clock named clk and an active high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is high
`define CHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define CHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cht_pkg.sv */
// shared constants and types of the chained hash table
// no dependencies
`timescale 1ns / 1ps

package cht_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int POOL_DEF    = 1024;

  localparam int KEY_W = 32;
  localparam int CFG_W = 11;
  localparam int IDX_W = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

endpackage

/* hw/rtl/cht_mod.sv */
// serial restoring remainder unit, one dividend bit per cycle
// depends on cht_pkg
`timescale 1ns / 1ps

module cht_mod #(
  parameter int CW = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [cht_pkg::KEY_W-1:0] dividend,
  input  logic [CW-1:0]           divisor,
  output logic                    done,
  output logic [CW-1:0]           rem
);

  localparam int RW    = CW + 1;
  localparam int CNT_W = $clog2(cht_pkg::KEY_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [cht_pkg::KEY_W-1:0] sh;
  logic [RW-1:0]             r;
  logic [RW-1:0]             r_sh;
  logic [RW-1:0]             r_next;

  always_comb begin
    r_sh = {r[CW-1:0], sh[cht_pkg::KEY_W-1]};
    if (r_sh >= {1'b0, divisor}) begin
      r_next = r_sh - {1'b0, divisor};
    end else begin
      r_next = r_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(cht_pkg::KEY_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      r  <= '0;
    end else if (cnt != '0) begin
      sh <= sh << 1;
      r  <= r_next;
    end
  end

  assign rem = r[CW-1:0];

endmodule

/* hw/rtl/chained_hash_table.sv */
// Hash set with separate chaining over a bounded node pool. An item inserts
// a signed key at the head of its bucket's chain or looks it up; the bucket
// is the floored remainder of the key by bucket_count. One item at a time:
// the item is accepted, runs through the serial remainder unit, fetches the
// bucket head, on a lookup walks the chain node by node, and hands over the
// result once the output is free. After reset a clearing pass writes every
// bucket head empty, during which no item is taken; config writes are taken
// at any time out of reset. Depends on cht_pkg, cht_mod and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chained_hash_table #(
  parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
  parameter int POOL    = cht_pkg::POOL_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cht_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic signed [cht_pkg::KEY_W-1:0] key,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cht_pkg::IDX_W-1:0] bucket_index,
  output logic                      found,
  output logic                      pool_full
);

  localparam int CW   = $clog2(BUCKETS + 1);
  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW   = $clog2(POOL + 1);
  localparam int AW   = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int CMPW = (CW > cht_pkg::CFG_W) ? CW : cht_pkg::CFG_W;

  localparam logic [PW-1:0] NIL = PW'(POOL);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state;
  logic [CW-1:0]             count;
  logic [BW-1:0]             clr;
  logic [PW-1:0]             used;
  logic                      op_q;
  logic [cht_pkg::KEY_W-1:0] key_q;
  logic [BW-1:0]             bucket;
  logic                      found_q;
  logic                      full_q;

  logic [PW-1:0]             heads [BUCKETS];
  logic [cht_pkg::KEY_W-1:0] node_keys [POOL];
  logic [PW-1:0]             node_links [POOL];
  logic [PW-1:0]             head_rd;
  logic [cht_pkg::KEY_W-1:0] key_rd;
  logic [PW-1:0]             link_rd;

  logic                      accept;
  logic [cht_pkg::KEY_W-1:0] mag;
  logic                      mod_done;
  logic [CW-1:0]             mod_rem;
  logic [CW-1:0]             fold;
  logic [CMPW-1:0]           cfg_ext;
  logic [CMPW-1:0]           cfg_sat;
  logic                      ins_ok;
  logic                      head_we;
  logic [BW-1:0]             head_wa;
  logic [PW-1:0]             head_wd;
  logic [PW-1:0]             node_ptr;
  logic                      out_free;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mag       = key[cht_pkg::KEY_W-1] ? (cht_pkg::KEY_W'(0) - key) : key;
  assign out_free  = !out_valid || out_ready;

  cht_mod #(
    .CW(CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (mag),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // floored remainder for negative keys
  assign fold = (key_q[cht_pkg::KEY_W-1] && mod_rem != '0) ? (count - mod_rem) : mod_rem;

  always_comb begin
    cfg_ext = CMPW'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_sat = CMPW'(1);
    end else if (cfg_ext > CMPW'(BUCKETS)) begin
      cfg_sat = CMPW'(BUCKETS);
    end else begin
      cfg_sat = cfg_ext;
    end
  end

  assign ins_ok   = (state == S_LINK) && (op_q == cht_pkg::OP_INSERT) && (used != NIL);
  assign head_we  = (state == S_CLEAR) || ins_ok;
  assign head_wa  = (state == S_CLEAR) ? clr : bucket;
  assign head_wd  = (state == S_CLEAR) ? NIL : used;
  assign node_ptr = (state == S_CMP) ? link_rd : head_rd;

  // bucket heads
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_wa] <= head_wd;
    end
    head_rd <= heads[bucket];
  end

  // node pool
  always_ff @(posedge clk) begin
    if (ins_ok) begin
      node_keys[used[AW-1:0]]  <= key_q;
      node_links[used[AW-1:0]] <= head_rd;
    end
    key_rd  <= node_keys[node_ptr[AW-1:0]];
    link_rd <= node_links[node_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      used      <= '0;
      count     <= CW'(BUCKETS);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= cfg_sat[CW-1:0];
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_LINK;
        end
        S_LINK: begin
          if (op_q == cht_pkg::OP_INSERT) begin
            if (used != NIL) begin
              used <= used + 1'b1;
            end
            state <= S_DONE;
          end else if (head_rd == NIL) begin
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_rd == key_q || link_rd == NIL) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      key_q   <= key;
      found_q <= 1'b0;
      full_q  <= 1'b0;
    end
    if (state == S_MOD && mod_done) begin
      bucket <= fold[BW-1:0];
    end
    if (state == S_LINK && op_q == cht_pkg::OP_INSERT && used == NIL) begin
      full_q <= 1'b1;
    end
    if (state == S_CMP && key_rd == key_q) begin
      found_q <= 1'b1;
    end
    if (state == S_DONE && out_free) begin
      bucket_index <= cht_pkg::idx_t'(bucket);
      found        <= found_q;
      pool_full    <= full_q;
    end
  end

  `CHT_ASSERT(a_ins_count, (ins_ok |=> used == $past(used) + 1'b1), "pool count not advanced")
  `CHT_ASSERT(a_mod_state, (mod_done |-> state == S_MOD), "remainder done outside its wait")
  `CHT_ASSERT(a_result_kind, (out_valid |-> !(found && pool_full)), "found and full together")
  `CHT_ASSERT_ALWAYS(a_pool_bound, (rst || used <= NIL), "pool count beyond pool size")

endmodule
